/* hdl/rhpa_pkg.sv */
// Package with the shared constants, codes and types of the handle pool allocator.
package rhpa_pkg;

  // Table geometry.
  localparam int POOL_SIZE = 64;
  localparam int SLOT_W    = $clog2(POOL_SIZE);

  // Field widths of the transactions.
  localparam int MODE_W   = 2;
  localparam int TAG_W    = 32;
  localparam int OTYPE_W  = 8;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 3;
  localparam int HOUT_W   = 17;
  localparam int OFFSET_W = 16;

  // Operation codes carried by a request.
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD          = 2'd0,
    MODE_LOOKUP       = 2'd1,
    MODE_LOOKUP_TYPED = 2'd2,
    MODE_REMOVE       = 2'd3
  } mode_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_FULL         = 3'd1,
    ST_NOT_POSITIVE = 3'd2,
    ST_RANGE        = 3'd3,
    ST_EMPTY        = 3'd4,
    ST_TYPE         = 3'd5
  } status_t;

  // One entry of the slot table.
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [OTYPE_W-1:0] obj_type;
  } slot_entry_t;

endpackage

/* hdl/rhpa_if.sv */
// Interfaces of the request and response channels of the handle pool allocator.
interface rhpa_req_if
  import rhpa_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [TAG_W-1:0]    object_tag;
  logic [OTYPE_W-1:0]  object_type;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, mode, object_tag, object_type, handle, input ready);
  modport sink (input valid, mode, object_tag, object_type, handle, output ready);
endinterface

interface rhpa_rsp_if
  import rhpa_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HOUT_W-1:0]   handle_out;
  logic [TAG_W-1:0]    tag_out;

  modport source (output valid, status, handle_out, tag_out, input ready);
  modport sink (input valid, status, handle_out, tag_out, output ready);
endinterface

/* hdl/rotating_handle_pool_allocator_unit.sv */
// Top level of the rotating handle pool allocator: control, occupancy and result register.
//
// In the accept cycle of a request the occupancy bits are checked, the free-slot search
// runs over them, and the slot table memory is written (add) or read (lookup); in the
// result cycle the registered table read is compared and the result is loaded into the
// output register. A new request is taken while that result waits on the response
// channel; a second result waits in the result cycle until the output register is free.
// Occupancy lives in flip-flops that reset clears at once, so no clearing pass follows
// reset. Slot tag and type are only read for occupied slots.
module rotating_handle_pool_allocator_unit
  import rhpa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  rhpa_req_if.sink            req,
  rhpa_rsp_if.source          rsp,
  input  logic                cfg_wr_en,
  input  logic [OFFSET_W-1:0] cfg_wr_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [OFFSET_W-1:0]   handle_offset;
  logic [POOL_SIZE-1:0]  slot_used;
  logic [SLOT_W-1:0]     search_start;

  // Operation held between the accept cycle and the result cycle.
  status_t               op_status;
  logic [HOUT_W-1:0]     op_hout;
  logic                  op_check;
  logic                  op_typed;
  logic [OTYPE_W-1:0]    op_type;

  // Output register.
  logic                  out_valid;
  status_t               out_status;
  logic [HOUT_W-1:0]     out_hout;
  logic [TAG_W-1:0]      out_tag;

  logic                  accept;
  mode_t                 req_mode;
  logic [HANDLE_W:0]     idx_diff;
  logic                  in_range;
  logic [SLOT_W-1:0]     idx_slot;
  logic                  free_found;
  logic [SLOT_W-1:0]     free_slot;
  status_t               acc_status;
  logic                  acc_check;
  logic                  do_alloc;
  logic                  do_free;
  logic                  load_out;
  slot_entry_t           wr_entry;
  slot_entry_t           rd_entry;
  status_t               res_status;
  logic [TAG_W-1:0]      res_tag;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign req_mode = mode_t'(req.mode);

  // Handle to slot index, without wrapping.
  assign idx_diff = {1'b0, req.handle} - (HANDLE_W+1)'(handle_offset);
  assign in_range = !idx_diff[HANDLE_W] && (idx_diff < (HANDLE_W+1)'(POOL_SIZE));
  assign idx_slot = idx_diff[SLOT_W-1:0];

  rhpa_free_search u_search (
    .used  (slot_used),
    .start (search_start),
    .found (free_found),
    .slot  (free_slot)
  );

  // Decode of the request in its accept cycle.
  always_comb begin
    acc_status = ST_OK;
    acc_check  = 1'b0;
    do_alloc   = 1'b0;
    do_free    = 1'b0;
    unique case (req_mode)
      MODE_ADD: begin
        if (free_found) begin
          do_alloc = accept;
        end else begin
          acc_status = ST_FULL;
        end
      end
      MODE_REMOVE: begin
        if (in_range) begin
          do_free = accept;
        end else begin
          acc_status = ST_RANGE;
        end
      end
      MODE_LOOKUP, MODE_LOOKUP_TYPED: begin
        if (req.handle == '0) begin
          acc_status = ST_NOT_POSITIVE;
        end else if (!in_range) begin
          acc_status = ST_RANGE;
        end else if (!slot_used[idx_slot]) begin
          acc_status = ST_EMPTY;
        end else begin
          acc_check = 1'b1;
        end
      end
      default: begin
        acc_status = ST_OK;
      end
    endcase
  end

  assign wr_entry = '{tag: req.object_tag, obj_type: req.object_type};

  rhpa_slot_ram u_ram (
    .clk     (clk),
    .wr_en   (do_alloc),
    .wr_addr (free_slot),
    .wr_data (wr_entry),
    .rd_en   (accept && acc_check),
    .rd_addr (idx_slot),
    .rd_data (rd_entry)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      handle_offset <= '0;
    end else if (cfg_wr_en) begin
      handle_offset <= cfg_wr_data;
    end
  end

  // Occupancy bits and the rotating start pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used    <= '0;
      search_start <= '0;
    end else begin
      if (do_alloc) begin
        slot_used[free_slot] <= 1'b1;
        if (search_start == SLOT_W'(POOL_SIZE - 1)) begin
          search_start <= '0;
        end else begin
          search_start <= search_start + SLOT_W'(1);
        end
      end
      if (do_free) begin
        slot_used[idx_slot] <= 1'b0;
      end
    end
  end

  // Operation register captured at accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_status <= acc_status;
      op_check  <= acc_check;
      op_typed  <= (req_mode == MODE_LOOKUP_TYPED);
      op_type   <= req.object_type;
      op_hout   <= do_alloc ? (HOUT_W'(handle_offset) + HOUT_W'(free_slot)) : '0;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result formation from the table read.
  always_comb begin
    res_status = op_status;
    res_tag    = '0;
    if (op_check) begin
      if (op_typed && (rd_entry.obj_type != op_type)) begin
        res_status = ST_TYPE;
      end else begin
        res_status = ST_OK;
        res_tag    = rd_entry.tag;
      end
    end
  end

  assign load_out = (state == S_RESP) && (!out_valid || rsp.ready);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= res_status;
      out_hout   <= op_hout;
      out_tag    <= res_tag;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.handle_out = out_hout;
  assign rsp.tag_out    = out_tag;

`ifndef NO_ASSERTIONS
  // Every accepted request moves the sequencer into the result cycle.
  a_accept_to_resp: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_RESP))
    else $error("accepted request did not enter the result cycle");

  // A successful add marks the chosen slot occupied.
  a_alloc_marks: assert property (@(posedge clk) disable iff (rst)
    do_alloc |=> slot_used[$past(free_slot)])
    else $error("allocated slot not marked occupied");

  // An in-range remove frees the named slot.
  a_free_clears: assert property (@(posedge clk) disable iff (rst)
    do_free |=> !slot_used[$past(idx_slot)])
    else $error("removed slot still marked occupied");

  // A new result appears only after a result cycle.
  a_out_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RESP))
    else $error("result raised outside the result cycle");

  // An add never picks a slot that is already occupied.
  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    do_alloc |-> !slot_used[free_slot])
    else $error("free search returned an occupied slot");
`endif

endmodule

/* hdl/rhpa_slot_ram.sv */
// Slot table memory holding the tag and type of every slot, with a registered read.
module rhpa_slot_ram
  import rhpa_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  slot_entry_t       wr_data,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output slot_entry_t       rd_data
);

  slot_entry_t mem [POOL_SIZE];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/rhpa_free_search.sv */
// Rotated priority encoder that finds the first free slot at or after the start pointer.
module rhpa_free_search
  import rhpa_pkg::*;
(
  input  logic [POOL_SIZE-1:0] used,
  input  logic [SLOT_W-1:0]    start,
  output logic                 found,
  output logic [SLOT_W-1:0]    slot
);

  logic [POOL_SIZE-1:0]   rotated;
  logic [SLOT_W-1:0]      distance;
  logic [SLOT_W:0]        slot_sum;

  // Rotate the occupancy so that the start slot lands at bit zero.
  assign rotated  = POOL_SIZE'({used, used} >> start);
  assign found    = ~&used;

  // Lowest free position in rotated order.
  always_comb begin
    distance = '0;
    for (int i = POOL_SIZE - 1; i >= 0; i--) begin
      if (!rotated[i]) begin
        distance = SLOT_W'(i);
      end
    end
  end

  // Map the distance back to a slot index, wrapping at the table size.
  assign slot_sum = {1'b0, start} + {1'b0, distance};

  always_comb begin
    if (slot_sum >= (SLOT_W+1)'(POOL_SIZE)) begin
      slot = SLOT_W'(slot_sum - (SLOT_W+1)'(POOL_SIZE));
    end else begin
      slot = slot_sum[SLOT_W-1:0];
    end
  end

endmodule

/* dv/rotating_handle_pool_allocator_unit_tb.sv */
// Self-checking testbench of the rotating handle pool allocator with its own slot table model.
module rotating_handle_pool_allocator_unit_tb;
  import rhpa_pkg::*;

  // Expected contents of one response transaction.
  typedef struct packed {
    status_t             status;
    logic [HOUT_W-1:0]   handle_out;
    logic [TAG_W-1:0]    tag_out;
  } pool_result_t;

  // Ready patterns of the response side.
  typedef enum int {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_SPARSE,
    RX_EVERY_THIRD
  } rx_pattern_t;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [OFFSET_W-1:0] cfg_wr_data;

  rhpa_req_if req_ch ();
  rhpa_rsp_if rsp_ch ();

  rotating_handle_pool_allocator_unit dut (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Model of the slot table, the rotating search pointer and the offset register.
  logic                pool_used [POOL_SIZE];
  logic [TAG_W-1:0]    pool_tag [POOL_SIZE];
  logic [OTYPE_W-1:0]  pool_type [POOL_SIZE];
  logic [SLOT_W-1:0]   next_search;
  logic [OFFSET_W-1:0] cur_offset;

  pool_result_t expected_results [$];
  int           mismatch_count;
  int           burst_left;
  bit           tx_gaps_on;
  int           rx_hold_cycles;

  // Clock with a 12 unit period.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The run is cut off if it hangs.
  initial begin : watchdog
    #(12 * 400000);
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Applies one request to the table model and returns the response it must give.
  function automatic pool_result_t predict_pool_op(input mode_t op,
                                                   input logic [TAG_W-1:0] tag,
                                                   input logic [OTYPE_W-1:0] otype,
                                                   input logic [HANDLE_W-1:0] hnd);
    pool_result_t      r;
    longint            idx;
    bit                in_range;
    bit                found;
    logic [SLOT_W-1:0] slot;
    r.status = ST_OK;
    r.handle_out = '0;
    r.tag_out = '0;
    idx = longint'(hnd) - longint'(cur_offset);
    in_range = (idx >= 0) && (idx < POOL_SIZE);
    case (op)
      MODE_ADD: begin
        // The search for a free slot starts at the rotating pointer and wraps.
        found = 1'b0;
        for (int k = 0; k < POOL_SIZE; k++) begin
          slot = next_search + SLOT_W'(k);
          if (!found && !pool_used[slot]) begin
            found = 1'b1;
            pool_used[slot] = 1'b1;
            pool_tag[slot] = tag;
            pool_type[slot] = otype;
            r.handle_out = HOUT_W'(int'(cur_offset) + int'(slot));
            next_search = next_search + 1'b1;
          end
        end
        if (!found) begin
          r.status = ST_FULL;
        end
      end
      MODE_REMOVE: begin
        // A remove frees any slot in range, occupied or not.
        if (in_range) begin
          pool_used[int'(idx)] = 1'b0;
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: begin
        if (hnd == '0) begin
          r.status = ST_NOT_POSITIVE;
        end else if (!in_range) begin
          r.status = ST_RANGE;
        end else if (!pool_used[int'(idx)]) begin
          r.status = ST_EMPTY;
        end else if (op == MODE_LOOKUP_TYPED && pool_type[int'(idx)] != otype) begin
          r.status = ST_TYPE;
        end else begin
          r.tag_out = pool_tag[int'(idx)];
        end
      end
    endcase
    return r;
  endfunction

  // Offers one request transaction, with random bursts and gaps, and records its result.
  task automatic send_request(input mode_t op, input logic [TAG_W-1:0] tag,
                              input logic [OTYPE_W-1:0] otype,
                              input logic [HANDLE_W-1:0] hnd);
    int gap;
    if (tx_gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    req_ch.valid       <= 1'b1;
    req_ch.mode        <= op;
    req_ch.object_tag  <= tag;
    req_ch.object_type <= otype;
    req_ch.handle      <= hnd;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_results.push_back(predict_pool_op(op, tag, otype, hnd));
    if (burst_left > 0) begin
      burst_left--;
    end
    @(negedge clk);
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // The offset register is only written while the block is idle.
  task automatic write_offset(input logic [OFFSET_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cur_offset = value;
  endtask

  // Mostly handles of slots near the offset, the rest edge cases and noise.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int                  c;
    int                  s;
    int                  span;
    bit                  found;
    logic [HANDLE_W-1:0] h;
    c = $urandom_range(0, 9);
    s = $urandom_range(0, POOL_SIZE - 1);
    h = HANDLE_W'(cur_offset) + HANDLE_W'(s);
    if (c < 4) begin
      found = 1'b0;
      for (int k = 0; k < POOL_SIZE; k++) begin
        if (!found && pool_used[(s + k) % POOL_SIZE]) begin
          found = 1'b1;
          h = HANDLE_W'(cur_offset) + HANDLE_W'((s + k) % POOL_SIZE);
        end
      end
    end else if (c == 6) begin
      h = HANDLE_W'(cur_offset) + HANDLE_W'(POOL_SIZE + $urandom_range(0, 15));
    end else if (c == 7) begin
      if (cur_offset > 0) begin
        span = (cur_offset < 16) ? int'(cur_offset) : 16;
        h = HANDLE_W'(cur_offset) - HANDLE_W'($urandom_range(1, span));
      end else begin
        h = $urandom();
      end
    end else if (c == 8) begin
      h = '0;
    end else if (c == 9) begin
      h = $urandom();
    end
    return h;
  endfunction

  task automatic send_random_op(input int add_pct);
    mode_t               op;
    logic [HANDLE_W-1:0] hnd;
    logic [OTYPE_W-1:0]  otype;
    int                  pick;
    longint              idx;
    pick = $urandom_range(0, 99);
    if (pick < add_pct) begin
      op = MODE_ADD;
    end else begin
      case (pick % 3)
        0: op = MODE_LOOKUP;
        1: op = MODE_LOOKUP_TYPED;
        default: op = MODE_REMOVE;
      endcase
    end
    hnd = pick_handle();
    otype = OTYPE_W'($urandom_range(0, 255));
    // Half of the typed lookups on a valid slot ask for the stored type.
    if (op == MODE_LOOKUP_TYPED && $urandom_range(0, 1) == 1) begin
      idx = longint'(hnd) - longint'(cur_offset);
      if (idx >= 0 && idx < POOL_SIZE) begin
        otype = pool_type[int'(idx)];
      end
    end
    send_request(op, $urandom(), otype, hnd);
  endtask

  // Error codes, handle zero, range edges, typed mismatches and the rotating start.
  task automatic test_directed();
    send_request(MODE_LOOKUP, 32'h0, 8'h0, 32'd0);
    send_request(MODE_LOOKUP_TYPED, 32'h0, 8'h0, 32'd0);
    send_request(MODE_LOOKUP, 32'h0, 8'h0, 32'd5);
    send_request(MODE_REMOVE, 32'h0, 8'h0, 32'd0);
    send_request(MODE_ADD, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    send_request(MODE_ADD, 32'h0, 8'h0, 32'h0);
    send_request(MODE_LOOKUP, 32'h0, 8'h0, 32'd0);
    send_request(MODE_LOOKUP, 32'h0, 8'h0, 32'd1);
    send_request(MODE_LOOKUP_TYPED, 32'h0, 8'h00, 32'd1);
    send_request(MODE_LOOKUP_TYPED, 32'h0, 8'hFF, 32'd1);
    send_request(MODE_LOOKUP, 32'h0, 8'h0, 32'd64);
    send_request(MODE_LOOKUP, 32'h0, 8'h0, 32'hFFFF_FFFF);
    send_request(MODE_REMOVE, 32'h0, 8'h0, 32'd64);
    send_request(MODE_REMOVE, 32'h0, 8'h0, 32'hFFFF_FFFF);
    send_request(MODE_REMOVE, 32'h0, 8'h0, 32'd1);
    send_request(MODE_LOOKUP, 32'h0, 8'h0, 32'd1);
    // The search starts past the slot freed just now.
    send_request(MODE_ADD, 32'h1234_5678, 8'h5A, 32'h0);
    write_offset(16'd1000);
    send_request(MODE_LOOKUP, 32'h0, 8'h0, 32'd999);
    send_request(MODE_REMOVE, 32'h0, 8'h0, 32'd999);
    send_request(MODE_LOOKUP, 32'h0, 8'h0, 32'd1000);
    send_request(MODE_LOOKUP, 32'h0, 8'h0, 32'd1063);
    send_request(MODE_LOOKUP, 32'h0, 8'h0, 32'd1064);
    send_request(MODE_ADD, 32'hA5A5_A5A5, 8'h3C, 32'h0);
  endtask

  // Fills the pool at the largest offset, overflows it, then empties it again.
  task automatic test_pool_full();
    write_offset(16'hFFFF);
    repeat (POOL_SIZE + 3) begin
      send_request(MODE_ADD, $urandom(), OTYPE_W'($urandom_range(0, 255)), $urandom());
    end
    send_request(MODE_LOOKUP, 32'h0, 8'h0, 32'h0000_FFFF + POOL_SIZE - 1);
    send_request(MODE_LOOKUP_TYPED, 32'h0, pool_type[10], 32'h0000_FFFF + 10);
    for (int i = 0; i < POOL_SIZE; i++) begin
      send_request(MODE_REMOVE, $urandom(), 8'h0, 32'h0000_FFFF + i);
    end
    send_request(MODE_LOOKUP, 32'h0, 8'h0, 32'h0000_FFFF + 10);
  endtask

  // The response side holds off while requests keep coming, then the sender waits it out.
  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    rx_hold_cycles = 80;
    repeat (16) send_random_op(50);
    tx_gaps_on = 1'b1;
    drain_results();
  endtask

  // Random traffic over several offsets, from remove-heavy to add-heavy.
  task automatic test_random_phases();
    logic [OFFSET_W-1:0] offsets [6];
    int                  add_pcts [6];
    offsets = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 16'h0000};
    add_pcts = '{40, 70, 45, 85, 30, 50};
    offsets[2] = OFFSET_W'($urandom());
    offsets[4] = OFFSET_W'($urandom());
    offsets[5] = OFFSET_W'($urandom_range(1, 63));
    for (int p = 0; p < 6; p++) begin
      write_offset(offsets[p]);
      for (int n = 0; n < 55; n++) begin
        if (n == 40 && $urandom_range(0, 1) == 1) begin
          drain_results();
        end
        send_random_op(add_pcts[p]);
      end
    end
  endtask

  // Every response transaction is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    pool_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, status %0d", rsp_ch.status));
      end else begin
        want = expected_results.pop_front();
        if (rsp_ch.status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", rsp_ch.status,
                                    want.status));
        end
        if (rsp_ch.handle_out !== want.handle_out) begin
          report_mismatch($sformatf("handle_out %0d, expected %0d", rsp_ch.handle_out,
                                    want.handle_out));
        end
        if (rsp_ch.tag_out !== want.tag_out) begin
          report_mismatch($sformatf("tag_out %h, expected %h", rsp_ch.tag_out,
                                    want.tag_out));
        end
      end
    end
  end

  // Response ready follows a changing pattern, or stays low during a forced hold-off.
  initial begin : rx_stall_gen
    rx_pattern_t pattern;
    int          left;
    int          phase;
    rsp_ch.ready = 1'b0;
    pattern = RX_ALWAYS;
    left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (left == 0) begin
          pattern = rx_pattern_t'($urandom_range(0, 3));
          left = $urandom_range(16, 96);
        end
        left--;
        phase++;
        case (pattern)
          RX_ALWAYS:   rsp_ch.ready <= 1'b1;
          RX_MOSTLY:   rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE:   rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default:     rsp_ch.ready <= (phase % 3 == 0);
        endcase
      end
    end
  end

  // Main sequence.
  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_ADD;
    req_ch.object_tag = '0;
    req_ch.object_type = '0;
    req_ch.handle = '0;
    mismatch_count = 0;
    burst_left = 0;
    tx_gaps_on = 1'b1;
    rx_hold_cycles = 0;
    cur_offset = '0;
    next_search = '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_used[i] = 1'b0;
      pool_tag[i] = '0;
      pool_type[i] = '0;
    end
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_pool_full();
    test_backpressure();
    test_random_phases();

    drain_results();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/rhpa_pkg.sv
hdl/rhpa_if.sv
hdl/rhpa_slot_ram.sv
hdl/rhpa_free_search.sv
hdl/rotating_handle_pool_allocator_unit.sv
dv/rotating_handle_pool_allocator_unit_tb.sv
